/* rtl/utf8d_pkg.sv */
// Shared types and constants for the six-byte UTF-8 stream decoder.
// No dependencies.
package utf8d_pkg;

  localparam int unsigned CpWidth  = 31;
  localparam int unsigned LenWidth = 3;

  localparam logic [7:0] ContMask = 8'hc0;
  localparam logic [7:0] ContTag  = 8'h80;
  localparam logic [7:0] ContBits = 8'h3f;

  // Decoder state carried between beats.
  typedef struct packed {
    logic [LenWidth-1:0] bytes_left;
    logic [CpWidth-1:0]  acc;
    logic [LenWidth-1:0] exp_len;
  } dec_state_t;

  // One result item.
  typedef struct packed {
    logic [CpWidth-1:0]  code_point;
    logic [LenWidth-1:0] seq_length;
    logic                error;
  } dec_result_t;

endpackage

/* rtl/utf8d_decode.sv */
// Single-byte decode step: next state and optional result from the current
// state and one byte. Depends on utf8d_pkg.
module utf8d_decode import utf8d_pkg::*; (
  input  logic [7:0]  data_byte_i,
  input  logic        last_i,
  input  dec_state_t  state_i,
  output dec_state_t  state_o,
  output logic        emit_o,
  output dec_result_t result_o
);

  localparam dec_state_t IdleState = '{bytes_left: '0, acc: '0, exp_len: '0};

  logic [LenWidth-1:0] lead_len;
  logic [CpWidth-1:0]  lead_payload;
  logic [CpWidth-1:0]  acc_shift;
  logic [LenWidth-1:0] left_dec;
  logic                bad_lead;
  logic                is_cont;

  always_comb begin
    lead_payload = '0;
    if (data_byte_i >= 8'hfc) begin
      lead_len = 3'd6;
      lead_payload[0] = data_byte_i[0];
    end else if (data_byte_i >= 8'hf8) begin
      lead_len = 3'd5;
      lead_payload[1:0] = data_byte_i[1:0];
    end else if (data_byte_i >= 8'hf0) begin
      lead_len = 3'd4;
      lead_payload[2:0] = data_byte_i[2:0];
    end else if (data_byte_i >= 8'he0) begin
      lead_len = 3'd3;
      lead_payload[3:0] = data_byte_i[3:0];
    end else begin
      lead_len = 3'd2;
      lead_payload[4:0] = data_byte_i[4:0];
    end
  end

  assign bad_lead  = (data_byte_i >= 8'hfe) || ((data_byte_i & ContMask) == ContTag);
  assign is_cont   = (data_byte_i & ContMask) == ContTag;
  assign acc_shift = {state_i.acc[CpWidth-7:0], data_byte_i[5:0] & ContBits[5:0]};
  assign left_dec  = state_i.bytes_left - 3'd1;

  always_comb begin
    state_o  = state_i;
    emit_o   = 1'b0;
    result_o = '{code_point: '0, seq_length: 3'd1, error: 1'b1};
    if (state_i.bytes_left == '0) begin
      // expecting a lead byte
      if (bad_lead) begin
        emit_o  = 1'b1;
        state_o = IdleState;
      end else if (!data_byte_i[7]) begin
        emit_o   = 1'b1;
        state_o  = IdleState;
        result_o = '{code_point: {{(CpWidth-8){1'b0}}, data_byte_i},
                     seq_length: 3'd1, error: 1'b0};
      end else if (last_i) begin
        emit_o  = 1'b1;
        state_o = IdleState;
      end else begin
        state_o = '{bytes_left: lead_len - 3'd1, acc: lead_payload, exp_len: lead_len};
      end
    end else if (!is_cont) begin
      // offending byte is consumed with the error
      emit_o              = 1'b1;
      state_o             = IdleState;
      result_o.seq_length = state_i.exp_len - state_i.bytes_left + 3'd1;
    end else if (left_dec == '0) begin
      emit_o   = 1'b1;
      state_o  = IdleState;
      result_o = '{code_point: acc_shift, seq_length: state_i.exp_len, error: 1'b0};
    end else if (last_i) begin
      emit_o              = 1'b1;
      state_o             = IdleState;
      result_o.seq_length = state_i.exp_len - left_dec;
    end else begin
      state_o.bytes_left = left_dec;
      state_o.acc        = acc_shift;
    end
  end

endmodule

/* rtl/utf8_stream_decoder.sv */
// Top level of the six-byte UTF-8 stream decoder: input register, decode
// step and result register. Depends on utf8d_pkg and utf8d_decode.
//
// One byte per beat goes in, and at most one code point, with its length and
// an error flag, comes out when a character completes or a sequence fails.
// The block takes a byte every clock as long as the result register drains.
// A result is valid once the beat that completes or fails its sequence has
// passed the input register and then the result register. Lead and
// continuation bytes that produce no result never stall. Only a result
// waiting at a stalled output holds back the input.
module utf8_stream_decoder import utf8d_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          data_byte_i,
  input  logic                end_of_input_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [CpWidth-1:0]  code_point_o,
  output logic [LenWidth-1:0] seq_length_o,
  output logic                error_o
);

  logic        in_valid_q;
  logic [7:0]  byte_q;
  logic        last_q;
  dec_state_t  state_q, state_d;
  logic        emit;
  dec_result_t result_d, result_q;
  logic        out_valid_q;
  logic        advance;

  utf8d_decode u_decode (
    .data_byte_i (byte_q),
    .last_i      (last_q),
    .state_i     (state_q),
    .state_o     (state_d),
    .emit_o      (emit),
    .result_o    (result_d)
  );

  // registered beat moves on when its result (if any) has a place to go
  assign advance    = in_valid_q && (!emit || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        state_q <= state_d;
      end
      if (advance && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= data_byte_i;
      last_q <= end_of_input_i;
    end
    if (advance && emit) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign code_point_o = result_q.code_point;
  assign seq_length_o = result_q.seq_length;
  assign error_o      = result_q.error;

endmodule
